### hdl/bpps_pkg.sv
// Package with the shared types and constants of the button packet parser.
`timescale 1ns / 1ps

package bpps_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int TEMP_W  = 11;
    localparam int STEP_W  = 8;
    localparam int VOL_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Packet characters.
    localparam logic [BYTE_W-1:0] CH_START = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;  // 'B'
    localparam logic [BYTE_W-1:0] CH_PRESS = 8'h31;  // '1'
    localparam logic [BYTE_W-1:0] CH_UP    = 8'h35;  // '5'
    localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h36;  // '6'
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h37;  // '7'
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h38;  // '8'

    // Register values after reset.
    localparam logic [TEMP_W-1:0] RST_TEMP_MIN  = 11'd600;
    localparam logic [TEMP_W-1:0] RST_TEMP_MAX  = 11'd1500;
    localparam logic [STEP_W-1:0] RST_TEMP_STEP = 8'd100;
    localparam logic [VOL_W-1:0]  RST_VOL_MAX   = 4'd15;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_MIN  = 2'd0,
        CFG_TEMP_MAX  = 2'd1,
        CFG_TEMP_STEP = 2'd2,
        CFG_VOL_MAX   = 2'd3
    } cfg_idx_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_EXPECT_B = 3'd1,
        PH_BUTTON   = 3'd2,
        PH_PRESS    = 3'd3,
        PH_CHECK    = 3'd4
    } phase_t;

endpackage

### hdl/button_packet_parser_setpoints_core.sv
// Top level of the button packet parser with temperature and volume setpoints.
`timescale 1ns / 1ps

// A word accepted on s_ goes through the input register, then the result register, to m_.
// Throughput: one word per cycle, set by the single parser step between the
// input register and the result register; m_ stalls only hold those two stages.
// Reset (aresetn low, synchronous): both stages empty, the parser hunts for '!',
// the bounds and step return to 600, 1500, 100, 15, temperature 600, volume 15.
module button_packet_parser_setpoints_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel: one received byte per word.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bpps_pkg::BYTE_W-1:0]      s_rx_byte,
    // Result channel: settings and flags after each byte.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bpps_pkg::TEMP_W-1:0]      m_temperature,
    output logic [bpps_pkg::VOL_W-1:0]       m_volume,
    output logic                             m_packet_done,
    output logic                             m_checksum_bad,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [bpps_pkg::TEMP_W-1:0] temp_min_reg;
    logic [bpps_pkg::TEMP_W-1:0] temp_max_reg;
    logic [bpps_pkg::STEP_W-1:0] temp_step_reg;
    logic [bpps_pkg::VOL_W-1:0]  vol_max_reg;

    // Input stage.
    logic                        in_valid_reg;
    logic [bpps_pkg::BYTE_W-1:0] in_byte_reg;

    // Parser state.
    bpps_pkg::phase_t            phase_reg, phase_next;
    logic [bpps_pkg::BYTE_W-1:0] button_reg, button_next;
    logic [bpps_pkg::BYTE_W-1:0] press_reg, press_next;
    logic [bpps_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [bpps_pkg::VOL_W-1:0]  vol_reg, vol_next;
    logic                        done_next, bad_next;

    // Result stage.
    logic                        out_valid_reg;
    logic [bpps_pkg::TEMP_W-1:0] out_temp_reg;
    logic [bpps_pkg::VOL_W-1:0]  out_vol_reg;
    logic                        out_done_reg;
    logic                        out_bad_reg;

    // The result stage moves whenever it is empty or its word is being taken,
    // and the input stage refills whenever it empties into the result stage.
    logic advance;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_min_reg  <= bpps_pkg::RST_TEMP_MIN;
            temp_max_reg  <= bpps_pkg::RST_TEMP_MAX;
            temp_step_reg <= bpps_pkg::RST_TEMP_STEP;
            vol_max_reg   <= bpps_pkg::RST_VOL_MAX;
        end else if (cfg_valid) begin
            case (cfg_index)
                bpps_pkg::CFG_TEMP_MIN:  temp_min_reg  <= cfg_data[bpps_pkg::TEMP_W-1:0];
                bpps_pkg::CFG_TEMP_MAX:  temp_max_reg  <= cfg_data[bpps_pkg::TEMP_W-1:0];
                bpps_pkg::CFG_TEMP_STEP: temp_step_reg <= cfg_data[bpps_pkg::STEP_W-1:0];
                bpps_pkg::CFG_VOL_MAX:   vol_max_reg   <= cfg_data[bpps_pkg::VOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Temperature arithmetic, one bit wider to catch the carry and the borrow.
    logic [bpps_pkg::TEMP_W:0]   temp_sum;
    logic [bpps_pkg::TEMP_W:0]   temp_diff;
    logic [bpps_pkg::TEMP_W-1:0] temp_up;
    logic [bpps_pkg::TEMP_W-1:0] temp_down;
    logic [bpps_pkg::BYTE_W-1:0] checksum;

    assign temp_sum  = {1'b0, temp_reg} + {{(bpps_pkg::TEMP_W + 1 - bpps_pkg::STEP_W){1'b0}},
                                           temp_step_reg};
    assign temp_diff = {1'b0, temp_reg} - {{(bpps_pkg::TEMP_W + 1 - bpps_pkg::STEP_W){1'b0}},
                                           temp_step_reg};

    always_comb begin
        // Raising saturates at the upper bound.
        if (temp_sum > {1'b0, temp_max_reg}) begin
            temp_up = temp_max_reg;
        end else begin
            temp_up = temp_sum[bpps_pkg::TEMP_W-1:0];
        end
        // Lowering saturates at the lower bound, also when the step would go below zero.
        if (!temp_diff[bpps_pkg::TEMP_W] && (temp_diff[bpps_pkg::TEMP_W-1:0] > temp_min_reg)) begin
            temp_down = temp_diff[bpps_pkg::TEMP_W-1:0];
        end else begin
            temp_down = temp_min_reg;
        end
    end

    // Expected checksum: inverted 8-bit sum of the first four packet bytes.
    assign checksum = ~(bpps_pkg::CH_START + bpps_pkg::CH_B + button_reg + press_reg);

    // Parser next state and result.
    always_comb begin
        phase_next  = phase_reg;
        button_next = button_reg;
        press_next  = press_reg;
        temp_next   = temp_reg;
        vol_next    = vol_reg;
        done_next   = 1'b0;
        bad_next    = 1'b0;
        case (phase_reg)
            bpps_pkg::PH_EXPECT_B: begin
                // Anything but 'B' drops the packet, a second '!' included.
                phase_next = (in_byte_reg == bpps_pkg::CH_B) ? bpps_pkg::PH_BUTTON
                                                             : bpps_pkg::PH_HUNT;
            end
            bpps_pkg::PH_BUTTON: begin
                button_next = in_byte_reg;
                phase_next  = bpps_pkg::PH_PRESS;
            end
            bpps_pkg::PH_PRESS: begin
                press_next = in_byte_reg;
                phase_next = bpps_pkg::PH_CHECK;
            end
            bpps_pkg::PH_CHECK: begin
                phase_next = bpps_pkg::PH_HUNT;
                if (in_byte_reg == checksum) begin
                    if (press_reg == bpps_pkg::CH_PRESS) begin
                        // An unknown button still completes the packet.
                        done_next = 1'b1;
                        case (button_reg)
                            bpps_pkg::CH_UP: begin
                                if (temp_reg < temp_max_reg) begin
                                    temp_next = temp_up;
                                end
                            end
                            bpps_pkg::CH_DOWN: begin
                                if (temp_reg > temp_min_reg) begin
                                    temp_next = temp_down;
                                end
                            end
                            bpps_pkg::CH_LEFT: begin
                                if (vol_reg != '0) begin
                                    vol_next = vol_reg - 1'b1;
                                end
                            end
                            bpps_pkg::CH_RIGHT: begin
                                if (vol_reg < vol_max_reg) begin
                                    vol_next = vol_reg + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end else begin
                    bad_next = 1'b1;
                end
            end
            default: begin
                phase_next = (in_byte_reg == bpps_pkg::CH_START) ? bpps_pkg::PH_EXPECT_B
                                                                 : bpps_pkg::PH_HUNT;
            end
        endcase
    end

    // Parser state steps once per byte that moves into the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= bpps_pkg::PH_HUNT;
            button_reg <= '0;
            press_reg  <= '0;
            temp_reg   <= bpps_pkg::RST_TEMP_MIN;
            vol_reg    <= bpps_pkg::RST_VOL_MAX;
        end else if (in_valid_reg && advance) begin
            phase_reg  <= phase_next;
            button_reg <= button_next;
            press_reg  <= press_next;
            temp_reg   <= temp_next;
            vol_reg    <= vol_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_temp_reg <= temp_next;
            out_vol_reg  <= vol_next;
            out_done_reg <= done_next;
            out_bad_reg  <= bad_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_temperature  = out_temp_reg;
    assign m_volume       = out_vol_reg;
    assign m_packet_done  = out_done_reg;
    assign m_checksum_bad = out_bad_reg;

endmodule

### hdl/bpps_checker.sv
// Port-level checker for the button packet parser and its bind statement.
`timescale 1ns / 1ps

module bpps_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [bpps_pkg::TEMP_W-1:0]      m_temperature,
    input logic [bpps_pkg::VOL_W-1:0]       m_volume,
    input logic                             m_packet_done,
    input logic                             m_checksum_bad
);

    // A byte cannot both complete a packet and fail its checksum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_packet_done && m_checksum_bad))
        else $error("packet_done and checksum_bad both set");

    // When the result side takes a word, the input side can always take one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is drained");

    // The result stage is empty right after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result word present right after reset");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature) && $stable(m_volume)
                                && $stable(m_packet_done) && $stable(m_checksum_bad))
        else $error("stalled result word changed");

endmodule

bind button_packet_parser_setpoints_core bpps_checker u_bpps_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_temperature  (m_temperature),
    .m_volume       (m_volume),
    .m_packet_done  (m_packet_done),
    .m_checksum_bad (m_checksum_bad)
);
